FILE: src/gbn_pkg.sv
// Shared constants, codes and types for the go-back-n sender.
package gbn_pkg;

   // Window storage; depth must be a power of two (slot is the low seq bits)
   localparam int WINDOW_DEPTH  = 32;
   localparam int SLOT_W        = $clog2(WINDOW_DEPTH);
   localparam int PAYLOAD_BYTES = 1024;
   localparam int MAX_OUT       = 32;
   localparam int WIN_CAP       = (WINDOW_DEPTH < MAX_OUT) ? WINDOW_DEPTH : MAX_OUT;

   // Field widths
   localparam int FUNC_W   = 3;
   localparam int LEN_W    = 11;
   localparam int FLAGS_W  = 3;
   localparam int SEQ_W    = 32;
   localparam int SLOT_O_W = 5;
   localparam int STAT_W   = 2;
   localparam int LIMIT_W  = 6;
   localparam int CNT_W    = $clog2(MAX_OUT + 1);

   // Request function codes
   localparam logic [FUNC_W-1:0] FN_START   = 3'd0;
   localparam logic [FUNC_W-1:0] FN_CHUNK   = 3'd1;
   localparam logic [FUNC_W-1:0] FN_EOF     = 3'd2;
   localparam logic [FUNC_W-1:0] FN_REPLY   = 3'd3;
   localparam logic [FUNC_W-1:0] FN_TIMEOUT = 3'd4;

   // Packet flags
   localparam logic [FLAGS_W-1:0] FLAG_NONE = 3'd0;
   localparam logic [FLAGS_W-1:0] FLAG_SYN  = 3'd1;
   localparam logic [FLAGS_W-1:0] FLAG_ACK  = 3'd2;
   localparam logic [FLAGS_W-1:0] FLAG_FIN  = 3'd4;

   // Response status codes
   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_REJECT  = 2'd1;
   localparam logic [STAT_W-1:0] ST_IGNORED = 2'd2;
   localparam logic [STAT_W-1:0] ST_DONE    = 2'd3;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd8;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SYN,
      PH_DATA,
      PH_FIN,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_DECIDE,
      CS_READ,
      CS_LOAD,
      CS_SEND
   } ctrl_state_type;

   // Controller -> datapath
   typedef struct packed {
      logic capture;   // latch request beat
      logic decide;    // evaluate request, update protocol state
      logic rd;        // read slot length for resend
      logic wload;     // load resend beat into output register
      logic advance;   // step resend index
   } ctrl_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic walk;      // request is a data-phase timeout with packets outstanding
      logic more;      // current output beat is not the last one
   } dp_sts_type;

endpackage

FILE: src/gbn_ctrl.sv
// Sequencing state machine for the go-back-n sender.
module gbn_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  gbn_pkg::dp_sts_type   sts,
   output gbn_pkg::ctrl_cmd_type cmd
);

   gbn_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gbn_pkg::CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         gbn_pkg::CS_IDLE: begin
            // no beat is taken while reset is held
            req_ready = !reset;
            if (req_valid && req_ready) begin
               cmd.capture = 1'b1;
               state_in    = gbn_pkg::CS_DECIDE;
            end
         end
         gbn_pkg::CS_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = sts.walk ? gbn_pkg::CS_READ : gbn_pkg::CS_SEND;
         end
         gbn_pkg::CS_READ: begin
            cmd.rd   = 1'b1;
            state_in = gbn_pkg::CS_LOAD;
         end
         gbn_pkg::CS_LOAD: begin
            cmd.wload = 1'b1;
            state_in  = gbn_pkg::CS_SEND;
         end
         gbn_pkg::CS_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (sts.more) begin
                  cmd.advance = 1'b1;
                  state_in    = gbn_pkg::CS_READ;
               end else begin
                  state_in = gbn_pkg::CS_IDLE;
               end
            end
         end
         default: begin
            state_in = gbn_pkg::CS_IDLE;
         end
      endcase
   end

endmodule

FILE: src/gbn_dp.sv
// Protocol state, slot length memory and output register of the go-back-n sender.
module gbn_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  gbn_pkg::ctrl_cmd_type               cmd,
   output gbn_pkg::dp_sts_type                 sts,
   input  logic                                csr_we,
   input  logic [gbn_pkg::LIMIT_W-1:0]         csr_data,
   input  logic [gbn_pkg::FUNC_W-1:0]          req_func,
   input  logic [gbn_pkg::LEN_W-1:0]           req_chunk_len,
   input  logic [gbn_pkg::FLAGS_W-1:0]         req_reply_flags,
   input  logic [gbn_pkg::SEQ_W-1:0]           req_reply_ack,
   output logic                                rsp_send_valid,
   output logic [gbn_pkg::SEQ_W-1:0]           rsp_seq_num,
   output logic [gbn_pkg::FLAGS_W-1:0]         rsp_pkt_flags,
   output logic [gbn_pkg::LEN_W-1:0]           rsp_pkt_len,
   output logic [gbn_pkg::SLOT_O_W-1:0]        rsp_slot,
   output logic                                rsp_last,
   output logic [gbn_pkg::STAT_W-1:0]          rsp_status
);

   localparam logic [gbn_pkg::LEN_W-1:0] LEN_SAT = gbn_pkg::LEN_W'(gbn_pkg::PAYLOAD_BYTES);
   localparam logic [gbn_pkg::LIMIT_W-1:0] LIM_CAP = gbn_pkg::LIMIT_W'(gbn_pkg::WIN_CAP);
   localparam logic [gbn_pkg::CNT_W-1:0] CNT_MAX = gbn_pkg::CNT_W'(gbn_pkg::MAX_OUT);

   // Architectural state
   gbn_pkg::phase_type              phase_ff, phase_in;
   logic [gbn_pkg::SEQ_W-1:0]       next_seq_ff, next_seq_in;
   logic [gbn_pkg::SEQ_W-1:0]       base_seq_ff, base_seq_in;
   logic                            eof_ff, eof_in;
   logic [gbn_pkg::LIMIT_W-1:0]     limit_ff;

   // Captured request beat
   logic [gbn_pkg::FUNC_W-1:0]      func_ff;
   logic [gbn_pkg::LEN_W-1:0]       clen_ff;
   logic [gbn_pkg::FLAGS_W-1:0]     rflags_ff;
   logic [gbn_pkg::SEQ_W-1:0]       rack_ff;

   // Resend walk
   logic [gbn_pkg::CNT_W-1:0]       idx_ff;
   logic [gbn_pkg::CNT_W-1:0]       cnt_ff;
   logic [gbn_pkg::LEN_W-1:0]       len_q_ff;

   // Output register
   logic                            o_send_ff;
   logic [gbn_pkg::SEQ_W-1:0]       o_seq_ff;
   logic [gbn_pkg::FLAGS_W-1:0]     o_flags_ff;
   logic [gbn_pkg::LEN_W-1:0]       o_len_ff;
   logic [gbn_pkg::SLOT_O_W-1:0]    o_slot_ff;
   logic                            o_last_ff;
   logic [gbn_pkg::STAT_W-1:0]      o_status_ff;

   logic [gbn_pkg::LEN_W-1:0]       len_mem [gbn_pkg::WINDOW_DEPTH];

   // Decision results
   logic                            d_send;
   logic [gbn_pkg::SEQ_W-1:0]       d_seq;
   logic [gbn_pkg::FLAGS_W-1:0]     d_flags;
   logic [gbn_pkg::LEN_W-1:0]       d_len;
   logic [gbn_pkg::SLOT_W-1:0]      d_slot;
   logic [gbn_pkg::STAT_W-1:0]      d_status;
   logic                            d_walk;
   logic                            d_we;

   logic [gbn_pkg::SEQ_W-1:0]       outstanding;
   logic [gbn_pkg::SEQ_W-1:0]       ack_off;
   logic [gbn_pkg::SEQ_W-1:0]       ack_next;
   logic [gbn_pkg::LIMIT_W-1:0]     eff_limit;
   logic [gbn_pkg::LEN_W-1:0]       clen_sat;
   logic [gbn_pkg::CNT_W-1:0]       walk_cnt;
   logic [gbn_pkg::SEQ_W-1:0]       walk_seq;
   logic [gbn_pkg::SLOT_W-1:0]      walk_slot;

   assign outstanding = next_seq_ff - base_seq_ff;
   assign ack_off     = rack_ff - base_seq_ff;
   assign ack_next    = rack_ff + 1'b1;
   assign clen_sat    = (clen_ff > LEN_SAT) ? LEN_SAT : clen_ff;
   assign walk_cnt    = (outstanding > gbn_pkg::SEQ_W'(gbn_pkg::MAX_OUT)) ?
                        CNT_MAX : gbn_pkg::CNT_W'(outstanding);
   assign walk_seq    = base_seq_ff + gbn_pkg::SEQ_W'(idx_ff);
   assign walk_slot   = walk_seq[gbn_pkg::SLOT_W-1:0];

   always_comb begin
      eff_limit = limit_ff;
      if (limit_ff == '0) begin
         eff_limit = gbn_pkg::LIMIT_W'(1);
      end else if (limit_ff > LIM_CAP) begin
         eff_limit = LIM_CAP;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      next_seq_in = next_seq_ff;
      base_seq_in = base_seq_ff;
      eof_in      = eof_ff;
      d_send      = 1'b0;
      d_seq       = '0;
      d_flags     = gbn_pkg::FLAG_NONE;
      d_len       = '0;
      d_slot      = '0;
      d_status    = gbn_pkg::ST_OK;
      d_walk      = 1'b0;
      d_we        = 1'b0;
      if (phase_ff == gbn_pkg::PH_IDLE && func_ff == gbn_pkg::FN_START) begin
         d_send      = 1'b1;
         d_flags     = gbn_pkg::FLAG_SYN;
         next_seq_in = gbn_pkg::SEQ_W'(1);
         base_seq_in = gbn_pkg::SEQ_W'(1);
         eof_in      = 1'b0;
         phase_in    = gbn_pkg::PH_SYN;
      end else if (phase_ff == gbn_pkg::PH_SYN &&
                   func_ff inside {gbn_pkg::FN_REPLY, gbn_pkg::FN_TIMEOUT}) begin
         if (func_ff == gbn_pkg::FN_REPLY &&
             rflags_ff == (gbn_pkg::FLAG_SYN | gbn_pkg::FLAG_ACK)) begin
            phase_in = gbn_pkg::PH_DATA;
         end else begin
            d_send  = 1'b1;
            d_flags = gbn_pkg::FLAG_SYN;
         end
      end else if (phase_ff == gbn_pkg::PH_FIN &&
                   func_ff inside {gbn_pkg::FN_REPLY, gbn_pkg::FN_TIMEOUT}) begin
         if (func_ff == gbn_pkg::FN_REPLY && rflags_ff == gbn_pkg::FLAG_ACK) begin
            phase_in = gbn_pkg::PH_DONE;
            d_status = gbn_pkg::ST_DONE;
         end else begin
            d_send  = 1'b1;
            d_seq   = next_seq_ff - 1'b1;
            d_flags = gbn_pkg::FLAG_FIN | gbn_pkg::FLAG_ACK;
         end
      end else if (phase_ff == gbn_pkg::PH_DATA && func_ff == gbn_pkg::FN_CHUNK) begin
         if (eof_ff) begin
            d_status = gbn_pkg::ST_IGNORED;
         end else if (clen_ff == '0) begin
            d_status = gbn_pkg::ST_OK;
         end else if (outstanding >= gbn_pkg::SEQ_W'(eff_limit)) begin
            d_status = gbn_pkg::ST_REJECT;
         end else begin
            d_send      = 1'b1;
            d_seq       = next_seq_ff;
            d_flags     = gbn_pkg::FLAG_ACK;
            d_len       = clen_sat;
            d_slot      = next_seq_ff[gbn_pkg::SLOT_W-1:0];
            d_we        = 1'b1;
            next_seq_in = next_seq_ff + 1'b1;
         end
      end else if (phase_ff == gbn_pkg::PH_DATA && func_ff == gbn_pkg::FN_EOF) begin
         eof_in = 1'b1;
         if (outstanding == '0) begin
            d_send      = 1'b1;
            d_seq       = next_seq_ff;
            d_flags     = gbn_pkg::FLAG_FIN | gbn_pkg::FLAG_ACK;
            next_seq_in = next_seq_ff + 1'b1;
            phase_in    = gbn_pkg::PH_FIN;
         end
      end else if (phase_ff == gbn_pkg::PH_DATA && func_ff == gbn_pkg::FN_REPLY) begin
         if (rflags_ff == gbn_pkg::FLAG_ACK && outstanding != '0 &&
             ack_off < outstanding) begin
            base_seq_in = ack_next;
            if (eof_ff && ack_next == next_seq_ff) begin
               d_send      = 1'b1;
               d_seq       = next_seq_ff;
               d_flags     = gbn_pkg::FLAG_FIN | gbn_pkg::FLAG_ACK;
               next_seq_in = next_seq_ff + 1'b1;
               phase_in    = gbn_pkg::PH_FIN;
            end
         end else begin
            d_status = gbn_pkg::ST_IGNORED;
         end
      end else if (phase_ff == gbn_pkg::PH_DATA && func_ff == gbn_pkg::FN_TIMEOUT) begin
         d_walk = (outstanding != '0);
      end else begin
         d_status = gbn_pkg::ST_IGNORED;
      end
   end

   assign sts.walk = d_walk;
   assign sts.more = !o_last_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= gbn_pkg::PH_IDLE;
         next_seq_ff <= '0;
         base_seq_ff <= '0;
         eof_ff      <= 1'b0;
         limit_ff    <= gbn_pkg::LIMIT_RESET;
         idx_ff      <= '0;
         cnt_ff      <= '0;
         o_last_ff   <= 1'b1;
      end else begin
         if (csr_we) begin
            limit_ff <= csr_data;
         end
         if (cmd.decide) begin
            phase_ff    <= phase_in;
            next_seq_ff <= next_seq_in;
            base_seq_ff <= base_seq_in;
            eof_ff      <= eof_in;
            idx_ff      <= '0;
            cnt_ff      <= walk_cnt;
            if (!d_walk) begin
               o_last_ff <= 1'b1;
            end
         end
         if (cmd.advance) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.wload) begin
            o_last_ff <= (idx_ff + 1'b1 == cnt_ff);
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff   <= req_func;
         clen_ff   <= req_chunk_len;
         rflags_ff <= req_reply_flags;
         rack_ff   <= req_reply_ack;
      end
      if (cmd.decide && !d_walk) begin
         o_send_ff   <= d_send;
         o_seq_ff    <= d_seq;
         o_flags_ff  <= d_flags;
         o_len_ff    <= d_len;
         o_slot_ff   <= gbn_pkg::SLOT_O_W'(d_slot);
         o_status_ff <= d_status;
      end
      if (cmd.wload) begin
         o_send_ff   <= 1'b1;
         o_seq_ff    <= walk_seq;
         o_flags_ff  <= gbn_pkg::FLAG_ACK;
         o_len_ff    <= len_q_ff;
         o_slot_ff   <= gbn_pkg::SLOT_O_W'(walk_slot);
         o_status_ff <= gbn_pkg::ST_OK;
      end
   end

   // Slot length memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.decide && d_we) begin
         len_mem[d_slot] <= clen_sat;
      end
      if (cmd.rd) begin
         len_q_ff <= len_mem[walk_slot];
      end
   end

   assign rsp_send_valid = o_send_ff;
   assign rsp_seq_num    = o_seq_ff;
   assign rsp_pkt_flags  = o_flags_ff;
   assign rsp_pkt_len    = o_len_ff;
   assign rsp_slot       = o_slot_ff;
   assign rsp_last       = o_last_ff;
   assign rsp_status     = o_status_ff;

   // Window never holds more than the slot store
   a_window_bound: assert property (@(posedge clock) disable iff (reset)
      outstanding <= gbn_pkg::SEQ_W'(gbn_pkg::WINDOW_DEPTH))
      else $error("outstanding count exceeds window depth");

   // A resend walk starts at the oldest packet with a nonempty window
   a_walk_start: assert property (@(posedge clock) disable iff (reset)
      cmd.decide && d_walk |=> idx_ff == '0 && cnt_ff != '0)
      else $error("resend walk started without outstanding packets");

   // Every resend beat lies inside the window
   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      cmd.wload |-> idx_ff < cnt_ff)
      else $error("resend index beyond window");

   // Base only moves forward within the window on a decision
   a_base_stable: assert property (@(posedge clock) disable iff (reset)
      !$past(cmd.decide) && !$past(reset) |-> $stable(base_seq_ff))
      else $error("base sequence changed outside a decision");

endmodule

FILE: src/go_back_n_sender.sv
// Go-back-n ARQ sender: top level joining the controller and the datapath.
// A taken request is captured, then decided into the output register, then sent when rsp_ready
// is high; a resend passes read and load before send. A new request waits for the last beat.
// Timeout resend: each packet steps through read (registered slot length read), load and send.
// Reset: synchronous, active high; phase idle, sequence numbers zero, window_limit 8.
// Slot length memory has no reset; only slots inside the outstanding window are ever read.
module go_back_n_sender (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [gbn_pkg::FUNC_W-1:0]     req_func,
   input  logic [gbn_pkg::LEN_W-1:0]      req_chunk_len,
   input  logic [gbn_pkg::FLAGS_W-1:0]    req_reply_flags,
   input  logic [gbn_pkg::SEQ_W-1:0]      req_reply_ack,
   // Response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_send_valid,
   output logic [gbn_pkg::SEQ_W-1:0]      rsp_seq_num,
   output logic [gbn_pkg::FLAGS_W-1:0]    rsp_pkt_flags,
   output logic [gbn_pkg::LEN_W-1:0]      rsp_pkt_len,
   output logic [gbn_pkg::SLOT_O_W-1:0]   rsp_slot,
   output logic                           rsp_last,
   output logic [gbn_pkg::STAT_W-1:0]     rsp_status,
   // Window limit register write
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gbn_pkg::LIMIT_W-1:0]    csr_window_limit
);

   gbn_pkg::ctrl_cmd_type cmd;
   gbn_pkg::dp_sts_type   sts;

   // Register writes are taken only while the controller is idle, so the
   // limit never changes under a request in flight.
   assign csr_ready = req_ready;

   // Controller: one request beat at a time. Each request passes through the decide
   // state; a timeout with packets outstanding then loops read/load/send
   // once per packet, oldest first, with last marking the final beat.
   gbn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: protocol phase, sequence window, per-slot length store and
   // the output register that holds each response beat until taken.
   gbn_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_we          (csr_valid & csr_ready),
      .csr_data        (csr_window_limit),
      .req_func        (req_func),
      .req_chunk_len   (req_chunk_len),
      .req_reply_flags (req_reply_flags),
      .req_reply_ack   (req_reply_ack),
      .rsp_send_valid  (rsp_send_valid),
      .rsp_seq_num     (rsp_seq_num),
      .rsp_pkt_flags   (rsp_pkt_flags),
      .rsp_pkt_len     (rsp_pkt_len),
      .rsp_slot        (rsp_slot),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status)
   );

endmodule
